// File: sv/h2r_pkg.sv
// Shared constants and types for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none
package h2r_pkg;

  localparam int CHANNEL_FRACTION_BITS = 16;

  localparam int CH_W       = 17;
  localparam int HUE_W      = 16;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  localparam int WRAP_W          = 17;
  localparam int HUE_OFFSET      = 34560;
  localparam int HUE_RECIP       = 4369;
  localparam int HUE_RECIP_W     = 13;
  localparam int HUE_RECIP_SHIFT = 22;
  localparam int IDX_W           = 7;
  localparam int RES_W           = 11;

  localparam int SECTOR_SPAN  = 960;
  localparam int SECTOR_HALF  = 480;
  localparam int SPAN_W       = 10;
  localparam int SPAN_SHIFT   = 6;
  localparam int SPAN_ODD     = 15;

  localparam int SEC_RECIP       = 43;
  localparam int SEC_PROD_W      = 12;
  localparam int SEC_RECIP_SHIFT = 8;
  localparam int SEC_QUOT_W      = 4;
  localparam int SECTORS         = 6;
  localparam int SECTOR_W        = 3;

  localparam int M_W            = CH_W + SPAN_W;
  localparam int BASE_W         = 27;
  localparam int QUOT_W         = 21;
  localparam int DIV15_RECIP    = 1118481;
  localparam int DIV15_RECIP_W  = 21;
  localparam int DIV15_SHIFT    = 24;
  localparam int CHQ_W          = 18;

  localparam logic [SECTOR_W-1:0] SEC_RED     = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_YELLOW  = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_GREEN   = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_CYAN    = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_BLUE    = 3'd4;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } stage_en_t;

endpackage
`default_nettype wire

// File: sv/h2r_hue_split.sv
// Hue wrap, sector index and in-sector remainder over three stages.
`timescale 1ns / 1ps
`default_nettype none
module h2r_hue_split (
  input  wire logic                              clk,
  input  wire h2r_pkg::stage_en_t                en,
  input  wire logic [h2r_pkg::HUE_W-1:0]         hue,
  output logic      [h2r_pkg::SPAN_W-1:0]        rem,
  output logic      [h2r_pkg::SECTOR_W-1:0]      sector
);

  localparam int HQ_W = h2r_pkg::WRAP_W + h2r_pkg::HUE_RECIP_W;

  logic [h2r_pkg::WRAP_W-1:0]     wrap;
  logic [h2r_pkg::WRAP_W-1:0]     wrap_next;
  logic [HQ_W-1:0]                hq;
  logic [HQ_W-1:0]                hq_next;
  logic [h2r_pkg::IDX_W-1:0]      q0;
  logic [h2r_pkg::RES_W-1:0]      r0;
  logic                           over;
  logic [h2r_pkg::IDX_W-1:0]      idx;
  logic [h2r_pkg::IDX_W-1:0]      idx_next;
  logic [h2r_pkg::SPAN_W-1:0]     rem_next;
  logic [h2r_pkg::SEC_PROD_W-1:0] sprod;
  logic [h2r_pkg::SEC_QUOT_W-1:0] squot;
  logic [h2r_pkg::SECTOR_W-1:0]   sector_next;

  always_comb begin
    wrap_next = h2r_pkg::WRAP_W'(h2r_pkg::HUE_OFFSET) + {hue[h2r_pkg::HUE_W-1], hue};
    hq_next   = HQ_W'(wrap_next) * HQ_W'(h2r_pkg::HUE_RECIP);

    q0   = h2r_pkg::IDX_W'(hq >> h2r_pkg::HUE_RECIP_SHIFT);
    r0   = h2r_pkg::RES_W'(wrap - h2r_pkg::WRAP_W'(q0) * h2r_pkg::WRAP_W'(h2r_pkg::SECTOR_SPAN));
    over = r0 >= h2r_pkg::RES_W'(h2r_pkg::SECTOR_SPAN);
    idx_next = over ? q0 + h2r_pkg::IDX_W'(1) : q0;
    rem_next = h2r_pkg::SPAN_W'(over ? r0 - h2r_pkg::RES_W'(h2r_pkg::SECTOR_SPAN) : r0);

    sprod = h2r_pkg::SEC_PROD_W'(idx) * h2r_pkg::SEC_PROD_W'(h2r_pkg::SEC_RECIP);
    squot = h2r_pkg::SEC_QUOT_W'(sprod >> h2r_pkg::SEC_RECIP_SHIFT);
    sector_next = h2r_pkg::SECTOR_W'(idx - h2r_pkg::IDX_W'(squot) *
                                           h2r_pkg::IDX_W'(h2r_pkg::SECTORS));
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      wrap <= wrap_next;
      hq   <= hq_next;
    end
    if (en.s2) begin
      idx <= idx_next;
      rem <= rem_next;
    end
    if (en.s3) begin
      sector <= sector_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/h2r_lane.sv
// One channel lane: round(v * (960*ONE - s*k) / (960*ONE)) over four stages.
`timescale 1ns / 1ps
`default_nettype none
module h2r_lane #(
  parameter int CHANNEL_FRACTION_BITS = h2r_pkg::CHANNEL_FRACTION_BITS
) (
  input  wire logic                           clk,
  input  wire h2r_pkg::stage_en_t             en,
  input  wire logic [h2r_pkg::CH_W-1:0]       sat,
  input  wire logic [h2r_pkg::CH_W-1:0]       val,
  input  wire logic [h2r_pkg::SPAN_W-1:0]     k,
  output logic      [h2r_pkg::CH_W-1:0]       result
);

  localparam int YW  = h2r_pkg::M_W + CHANNEL_FRACTION_BITS;
  localparam int PW  = h2r_pkg::CH_W + h2r_pkg::M_W;
  localparam int DW  = h2r_pkg::QUOT_W + h2r_pkg::DIV15_RECIP_W;

  logic [h2r_pkg::M_W-1:0]    m3;
  logic [h2r_pkg::CH_W-1:0]   v3;
  logic [PW-1:0]              prod4;
  logic [YW-1:0]              x4;
  logic [h2r_pkg::CH_W-1:0]   v4;
  logic [h2r_pkg::BASE_W-1:0] base5;
  logic [YW-1:0]              y5;
  logic [h2r_pkg::QUOT_W-1:0] z5_next;
  logic [h2r_pkg::QUOT_W-1:0] z5;
  logic [DW-1:0]              prod6;
  logic [h2r_pkg::CHQ_W-1:0]  qq6_next;
  logic [h2r_pkg::CHQ_W-1:0]  qq6;
  logic [h2r_pkg::QUOT_W-1:0] z6;
  logic [h2r_pkg::QUOT_W-1:0] r6;

  always_comb begin
    prod4   = PW'(v3) * PW'(m3);
    base5   = h2r_pkg::BASE_W'(v4) * h2r_pkg::BASE_W'(h2r_pkg::SECTOR_SPAN) +
              h2r_pkg::BASE_W'(h2r_pkg::SECTOR_HALF);
    y5      = (YW'(base5) << CHANNEL_FRACTION_BITS) - x4;
    z5_next = h2r_pkg::QUOT_W'(y5 >> (CHANNEL_FRACTION_BITS + h2r_pkg::SPAN_SHIFT));
    prod6   = DW'(z5) * DW'(h2r_pkg::DIV15_RECIP);
    qq6_next = h2r_pkg::CHQ_W'(prod6 >> h2r_pkg::DIV15_SHIFT);
    r6      = z6 - h2r_pkg::QUOT_W'(qq6) * h2r_pkg::QUOT_W'(h2r_pkg::SPAN_ODD);
    result  = (r6 >= h2r_pkg::QUOT_W'(h2r_pkg::SPAN_ODD)) ?
              h2r_pkg::CH_W'(qq6 + h2r_pkg::CHQ_W'(1)) : h2r_pkg::CH_W'(qq6);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      m3 <= h2r_pkg::M_W'(sat) * h2r_pkg::M_W'(k);
      v3 <= val;
    end
    if (en.s4) begin
      x4 <= YW'(prod4);
      v4 <= v3;
    end
    if (en.s5) begin
      z5 <= z5_next;
    end
    if (en.s6) begin
      z6  <= z5;
      qq6 <= qq6_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: stage control, lanes and channel select.
//
//   channel | dir | word fields (lsb first)
//   s_*     | in  | hue[15:0], saturation[32:16], brightness[49:33], alpha[66:50]
//   m_*     | out | red[16:0], green[33:17], blue[50:34], alpha[67:51]
//
// Seven register stages; a word passes through them in order, stage 1 to stage 7, before it leaves.
// One word per cycle sustained while m_tready stays high; the lane multipliers are each one stage deep.
// Each stage holds its word until the next stage frees, so bubbles close up.
// rst clears every stage valid bit; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module hsv_to_rgb_converter #(
  parameter int CHANNEL_FRACTION_BITS = h2r_pkg::CHANNEL_FRACTION_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // hue, saturation, brightness, alpha
  input  wire logic [h2r_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // red, green, blue, alpha
  output logic      [h2r_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int CW    = h2r_pkg::CH_W;
  localparam int ONE_W = (CHANNEL_FRACTION_BITS + 1 > CW) ? CHANNEL_FRACTION_BITS + 1 : CW;
  localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << CHANNEL_FRACTION_BITS;
  localparam int PAD_W = h2r_pkg::OUT_DATA_W - 4 * CW;

  function automatic logic [CW-1:0] sat_one(input logic [CW-1:0] x);
    sat_one = (ONE_W'(x) > ONE) ? CW'(ONE) : x;
  endfunction

  logic [7:1]                     vld;
  logic [7:1]                     adv;
  h2r_pkg::stage_en_t             en;

  logic [h2r_pkg::HUE_W-1:0]      hue;
  logic [CW-1:0]                  sat1, val1, alp1;
  logic [CW-1:0]                  sat2, val2, alp2;
  logic [CW-1:0]                  val3, val4, val5, val6;
  logic [CW-1:0]                  alp3, alp4, alp5, alp6;
  logic [h2r_pkg::SECTOR_W-1:0]   sec3, sec4, sec5, sec6;
  logic [h2r_pkg::SPAN_W-1:0]     rem2;
  logic [h2r_pkg::SPAN_W-1:0]     k_t;
  logic [CW-1:0]                  p6, q6, t6;
  logic [CW-1:0]                  red_next, green_next, blue_next;
  logic [CW-1:0]                  red7, green7, blue7, alp7;

  assign hue = s_tdata[h2r_pkg::HUE_W-1:0];

  always_comb begin
    adv[7] = !vld[7] || m_tready;
    for (int i = 6; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
    en = '{s1: adv[1], s2: adv[2], s3: adv[3], s4: adv[4],
           s5: adv[5], s6: adv[6], s7: adv[7]};
  end

  assign s_tready = adv[1];
  assign m_tvalid = vld[7];
  assign m_tdata  = {PAD_W'(0), alp7, blue7, green7, red7};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int i = 2; i <= 7; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  h2r_hue_split u_hue (
    .clk    (clk),
    .en     (en),
    .hue    (hue),
    .rem    (rem2),
    .sector (sec3)
  );

  assign k_t = h2r_pkg::SPAN_W'(h2r_pkg::SECTOR_SPAN) - rem2;

  h2r_lane #(.CHANNEL_FRACTION_BITS(CHANNEL_FRACTION_BITS)) u_lane_p (
    .clk    (clk),
    .en     (en),
    .sat    (sat2),
    .val    (val2),
    .k      (h2r_pkg::SPAN_W'(h2r_pkg::SECTOR_SPAN)),
    .result (p6)
  );

  h2r_lane #(.CHANNEL_FRACTION_BITS(CHANNEL_FRACTION_BITS)) u_lane_q (
    .clk    (clk),
    .en     (en),
    .sat    (sat2),
    .val    (val2),
    .k      (rem2),
    .result (q6)
  );

  h2r_lane #(.CHANNEL_FRACTION_BITS(CHANNEL_FRACTION_BITS)) u_lane_t (
    .clk    (clk),
    .en     (en),
    .sat    (sat2),
    .val    (val2),
    .k      (k_t),
    .result (t6)
  );

  always_comb begin
    case (sec6)
      h2r_pkg::SEC_RED: begin
        red_next = val6; green_next = t6;   blue_next = p6;
      end
      h2r_pkg::SEC_YELLOW: begin
        red_next = q6;   green_next = val6; blue_next = p6;
      end
      h2r_pkg::SEC_GREEN: begin
        red_next = p6;   green_next = val6; blue_next = t6;
      end
      h2r_pkg::SEC_CYAN: begin
        red_next = p6;   green_next = q6;   blue_next = val6;
      end
      h2r_pkg::SEC_BLUE: begin
        red_next = t6;   green_next = p6;   blue_next = val6;
      end
      default: begin
        red_next = val6; green_next = p6;   blue_next = q6;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sat1 <= sat_one(s_tdata[h2r_pkg::HUE_W +: CW]);
      val1 <= sat_one(s_tdata[h2r_pkg::HUE_W + CW +: CW]);
      alp1 <= sat_one(s_tdata[h2r_pkg::HUE_W + 2 * CW +: CW]);
    end
    if (adv[2]) begin
      sat2 <= sat1;
      val2 <= val1;
      alp2 <= alp1;
    end
    if (adv[3]) begin
      val3 <= val2;
      alp3 <= alp2;
    end
    if (adv[4]) begin
      val4 <= val3;
      alp4 <= alp3;
      sec4 <= sec3;
    end
    if (adv[5]) begin
      val5 <= val4;
      alp5 <= alp4;
      sec5 <= sec4;
    end
    if (adv[6]) begin
      val6 <= val5;
      alp6 <= alp5;
      sec6 <= sec5;
    end
    if (adv[7]) begin
      red7   <= red_next;
      green7 <= green_next;
      blue7  <= blue_next;
      alp7   <= alp6;
    end
  end

endmodule
`default_nettype wire

// File: sv/h2r_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module h2r_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [h2r_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int USED_W = 4 * h2r_pkg::CH_W;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[h2r_pkg::OUT_DATA_W-1:USED_W] == '0)
    else $error("output pad bits not zero");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  a_ready_when_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |-> s_tready)
    else $error("input stalled while output drains");

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
